// ===== hw/rtl/pcbme_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbme_pkg
// Types and constants for the coil balance PI controller with mass estimate.
// ----------------------------------------------------------------------------
package pcbme_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int GAIN_FRAC   = 8;
  localparam int MCONST_FRAC = 24;
  localparam int SH          = GAIN_FRAC + FRAC_BITS;

  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ACCEL_W = 16;
  localparam int SETP_W  = 13;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int DUTY_W  = 11;
  localparam int MASS_W  = 24;
  localparam int INTEG_W = 16;
  localparam int ERR_W   = 18;
  localparam int HI_W    = 20;
  localparam int KC_W    = 27;
  localparam int CNT_W   = 5;
  localparam int TOTAL_W = HI_W + GAIN_W;
  localparam int LR_W    = 20;
  localparam int P_W     = HI_W + KC_W;
  localparam int Z_W     = 48;
  localparam int Q_W     = 36;
  localparam int LIGHT_SHIFT = MCONST_FRAC - FRAC_BITS;

  localparam logic [KC_W-1:0] K_HEAVY_SLOPE = KC_W'(66098876);
  localparam logic [KC_W-1:0] K_LIGHT_SLOPE = KC_W'(53687);
  localparam logic [Z_W-1:0]  C_HEAVY = (Z_W'(8517793) << FRAC_BITS)
                                      + (Z_W'(1) << (MCONST_FRAC - 1));
  localparam logic [Z_W-1:0]  C_LIGHT = Z_W'(26419082) + (Z_W'(1) << (LIGHT_SHIFT - 1));

  localparam int MASS_SWITCH = 1000;
  localparam int MASS_MAX    = 8388607;
  localparam int MASS_MIN    = -8388608;
  localparam int DUTY_TOP    = 2047;

  localparam logic [DUTY_W-1:0]  LEFT_RESET      = DUTY_W'(600);
  localparam logic [SETP_W-1:0]  SETPOINT_RESET  = SETP_W'(82);
  localparam logic [GAIN_W-1:0]  PROP_RESET      = GAIN_W'(2048);
  localparam logic [GAIN_W-1:0]  INTEG_RESET     = GAIN_W'(1280);
  localparam logic [LIM_W-1:0]   IN_LIM_RESET    = LIM_W'(1229);
  localparam logic [LIM_W-1:0]   INTEG_LIM_RESET = LIM_W'(205);
  localparam logic [DUTY_W-1:0]  DUTY_SUM_RESET  = DUTY_W'(1300);
  localparam logic [DUTY_W-1:0]  DUTY_MAX_RESET  = DUTY_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_PROP_GAIN  = 3'd1,
    REG_INTEG_GAIN = 3'd2,
    REG_IN_LIMIT   = 3'd3,
    REG_INTEG_LIM  = 3'd4,
    REG_DUTY_SUM   = 3'd5,
    REG_DUTY_MAX   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_PI,
    ST_LEFT,
    ST_MUL_MASS,
    ST_ROUND,
    ST_SAT
  } state_t;

endpackage

// ===== hw/rtl/pi_coil_balance_with_mass_estimate.sv =====
// ----------------------------------------------------------------------------
// pi_coil_balance_with_mass_estimate
// PI balance loop on accel Y with anti-windup, coil duties and mass estimate.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_*     | in        | tdata[15:0] accel_y
//  m_*     | out       | tdata[10:0] left_duty, [21:11] right_duty, [45:22] mass_est
//  cfg_*   | in        | cfg_index register number, cfg_data value
//
//  steps per sample: accept, clamp, the PI products, left/right update,
//  the mass product, then round and saturate
//  both products run through one shift-add unit, one multiplier bit a cycle
//  a finished result waits in the output register while the next sample starts
//  synchronous reset restores register defaults, integral 0, left level 600
// ----------------------------------------------------------------------------
module pi_coil_balance_with_mass_estimate (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pcbme_pkg::S_TDATA_W-1:0]   s_tdata,   // accel_y
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pcbme_pkg::M_TDATA_W-1:0]   m_tdata,   // left_duty, right_duty, mass_est
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcbme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcbme_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pcbme_pkg::*;

  state_t state, state_next;

  logic signed [SETP_W-1:0]  setpoint;
  logic [GAIN_W-1:0]         prop_gain;
  logic [GAIN_W-1:0]         integ_gain;
  logic [LIM_W-1:0]          input_limit;
  logic [LIM_W-1:0]          integral_limit;
  logic [DUTY_W-1:0]         duty_sum;
  logic [DUTY_W-1:0]         duty_max;

  logic signed [ACCEL_W-1:0] accel;
  logic signed [INTEG_W-1:0] integral_acc;
  logic [DUTY_W-1:0]         left_level;
  logic signed [ERR_W-1:0]   a_op;
  logic signed [INTEG_W-1:0] b_op;
  logic signed [HI_W-1:0]    hi;
  logic [KC_W-1:0]           lo;
  logic [KC_W-1:0]           mplr_a;
  logic [GAIN_W-1:0]         mplr_b;
  logic [CNT_W-1:0]          cnt;
  logic                      heavy;
  logic [Z_W-1:0]            zsum;
  logic [DUTY_W-1:0]         left_out;
  logic [DUTY_W-1:0]         right_out;

  logic do_accept, do_prep, do_step, do_left, do_round, do_out;
  logic out_free, last_pi, last_mass;

  // clamp and error
  logic signed [ACCEL_W:0]   y_ext, in_lim, actual;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W:0]     isum, ilim;
  logic signed [INTEG_W-1:0] integ;

  // shift-add step
  logic signed [HI_W:0]      sum;

  // left update
  logic signed [TOTAL_W-1:0] total;
  logic                      rem_nz;
  logic signed [LR_W-1:0]    lsum, l_raw, r_raw;
  logic                      heavy_now;
  logic signed [ERR_W-1:0]   v;
  logic [DUTY_W-1:0]         left_cl, right_cl;

  // mass
  logic signed [P_W-1:0]     prod;
  logic [Z_W-1:0]            z_now;
  logic signed [Q_W-1:0]     k, q;
  logic                      low_zero;
  logic [MASS_W-1:0]         mass_cl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= SETPOINT_RESET;
      prop_gain      <= PROP_RESET;
      integ_gain     <= INTEG_RESET;
      input_limit    <= IN_LIM_RESET;
      integral_limit <= INTEG_LIM_RESET;
      duty_sum       <= DUTY_SUM_RESET;
      duty_max       <= DUTY_MAX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SETPOINT:   setpoint       <= cfg_data[SETP_W-1:0];
        REG_PROP_GAIN:  prop_gain      <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain     <= cfg_data[GAIN_W-1:0];
        REG_IN_LIMIT:   input_limit    <= cfg_data[LIM_W-1:0];
        REG_INTEG_LIM:  integral_limit <= cfg_data[LIM_W-1:0];
        REG_DUTY_SUM:   duty_sum       <= cfg_data[DUTY_W-1:0];
        REG_DUTY_MAX:   duty_max       <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign last_pi   = (cnt == CNT_W'(GAIN_W - 1));
  assign last_mass = (cnt == CNT_W'(KC_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_PREP;
      ST_PREP:     state_next = ST_MUL_PI;
      ST_MUL_PI:   if (last_pi) state_next = ST_LEFT;
      ST_LEFT:     state_next = ST_MUL_MASS;
      ST_MUL_MASS: if (last_mass) state_next = ST_ROUND;
      ST_ROUND:    state_next = ST_SAT;
      ST_SAT:      if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    do_accept = 1'b0;
    do_prep   = 1'b0;
    do_step   = 1'b0;
    do_left   = 1'b0;
    do_round  = 1'b0;
    do_out    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        do_accept = s_tvalid;
      end
      ST_PREP:     do_prep  = 1'b1;
      ST_MUL_PI:   do_step  = 1'b1;
      ST_LEFT:     do_left  = 1'b1;
      ST_MUL_MASS: do_step  = 1'b1;
      ST_ROUND:    do_round = 1'b1;
      ST_SAT:      do_out   = out_free;
      default: ;
    endcase
  end

  // input clamp, error and anti-windup integral
  always_comb begin
    y_ext  = (ACCEL_W + 1)'(accel);
    in_lim = signed'((ACCEL_W + 1)'(input_limit));
    if (y_ext > in_lim) begin
      actual = in_lim;
    end else if (y_ext < -in_lim) begin
      actual = -in_lim;
    end else begin
      actual = y_ext;
    end
    err  = ERR_W'(setpoint) - ERR_W'(actual);
    isum = (ERR_W + 1)'(integral_acc) + (ERR_W + 1)'(err);
    ilim = signed'((ERR_W + 1)'(integral_limit));
    if (isum > ilim) begin
      integ = INTEG_W'(ilim);
    end else if (isum < -ilim) begin
      integ = INTEG_W'(-ilim);
    end else begin
      integ = INTEG_W'(isum);
    end
  end

  assign sum = (HI_W + 1)'(hi)
             + (mplr_a[0] ? (HI_W + 1)'(a_op) : '0)
             + (mplr_b[0] ? (HI_W + 1)'(b_op) : '0);

  // new left level, truncated toward zero
  always_comb begin
    total  = {hi, lo[KC_W-1 -: GAIN_W]};
    rem_nz = |total[SH-1:0];
    lsum   = LR_W'(signed'(total[TOTAL_W-1:SH])) + signed'(LR_W'(left_level));
    l_raw  = lsum + ((lsum < 0 && rem_nz) ? LR_W'(1) : LR_W'(0));
    r_raw  = signed'(LR_W'(duty_sum)) - l_raw;
    heavy_now = (l_raw >= MASS_SWITCH);
    v = heavy_now ? -ERR_W'(accel) : ERR_W'(-r_raw);
    if (l_raw < 0) begin
      left_cl = '0;
    end else if (l_raw > signed'(LR_W'(duty_max))) begin
      left_cl = duty_max;
    end else begin
      left_cl = l_raw[DUTY_W-1:0];
    end
    if (r_raw < 0) begin
      right_cl = '0;
    end else if (r_raw > DUTY_TOP) begin
      right_cl = DUTY_W'(DUTY_TOP);
    end else begin
      right_cl = r_raw[DUTY_W-1:0];
    end
  end

  // round half away from zero, then saturate
  always_comb begin
    prod  = {hi, lo};
    z_now = Z_W'(prod) + (heavy ? C_HEAVY : C_LIGHT);
    if (heavy) begin
      k        = Q_W'(signed'(zsum[Z_W-1:MCONST_FRAC]));
      low_zero = (zsum[MCONST_FRAC-1:0] == '0);
    end else begin
      k        = signed'(zsum[Z_W-1:LIGHT_SHIFT]);
      low_zero = (zsum[LIGHT_SHIFT-1:0] == '0);
    end
    q = k - ((low_zero && k <= 0) ? Q_W'(1) : Q_W'(0));
    if (q > MASS_MAX) begin
      mass_cl = MASS_W'(MASS_MAX);
    end else if (q < MASS_MIN) begin
      mass_cl = MASS_W'(MASS_MIN);
    end else begin
      mass_cl = q[MASS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      left_level   <= LEFT_RESET;
    end else begin
      if (do_prep) integral_acc <= integ;
      if (do_left) left_level   <= left_cl;
    end
  end

  always_ff @(posedge clk) begin
    if (do_accept) accel <= s_tdata;
    if (do_prep) begin
      a_op   <= err;
      b_op   <= integ;
      mplr_a <= KC_W'(prop_gain);
      mplr_b <= integ_gain;
      hi     <= '0;
      lo     <= '0;
      cnt    <= '0;
    end else if (do_left) begin
      a_op      <= v;
      mplr_a    <= heavy_now ? K_HEAVY_SLOPE : K_LIGHT_SLOPE;
      mplr_b    <= '0;
      hi        <= '0;
      lo        <= '0;
      cnt       <= '0;
      heavy     <= heavy_now;
      left_out  <= left_cl;
      right_out <= right_cl;
    end else if (do_step) begin
      hi     <= sum[HI_W:1];
      lo     <= {sum[0], lo[KC_W-1:1]};
      mplr_a <= mplr_a >> 1;
      mplr_b <= mplr_b >> 1;
      cnt    <= cnt + CNT_W'(1);
    end
    if (do_round) zsum <= z_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_out) begin
      m_tdata <= {(M_TDATA_W - MASS_W - 2 * DUTY_W)'(0), mass_cl, right_out, left_out};
    end
  end

endmodule

// ===== hw/rtl/pcbme_check.sv =====
// ----------------------------------------------------------------------------
// pcbme_check
// Port-level checks for the coil balance controller, bound to the top level.
// ----------------------------------------------------------------------------
module pcbme_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [pcbme_pkg::M_TDATA_W-1:0]   m_tdata
);
  import pcbme_pkg::*;

  // one sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a sample is in flight");

  // a new result only comes out of the busy phase
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a sample in work");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_TDATA_W-1:MASS_W+2*DUTY_W] == '0)
    else $error("padding bits of result beat not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

endmodule

bind pi_coil_balance_with_mass_estimate pcbme_check u_pcbme_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/pcbme_checker.sv =====
// ----------------------------------------------------------------------------
// pcbme_checker
// Watches the config, sample and duty channels of the coil balance loop,
// keeps its own copy of the registers and loop state, predicts left duty,
// right duty and mass estimate for every accepted sample, and compares each
// output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pcbme_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [pcbme_pkg::S_TDATA_W-1:0]   s_tdata,   // accel_y
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [pcbme_pkg::M_TDATA_W-1:0]   m_tdata,   // left_duty, right_duty, mass_est
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [pcbme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcbme_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                mismatch_count,
  output int                                results_waiting,
  output int                                results_checked,
  output int                                heavy_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcbme_pkg::*;

  localparam longint HEAVY_SLOPE_Q24 = 66098876;
  localparam longint HEAVY_OFFS_Q24  = 8517793;
  localparam longint LIGHT_SLOPE_Q24 = 53687;
  localparam longint LIGHT_OFFS_Q24  = 26419082;
  localparam int     REPORT_MAX      = 10;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic [MASS_W-1:0] mass_est;
    logic              heavy;
  } coil_result_t;

  logic signed [SETP_W-1:0]  setp;
  logic [GAIN_W-1:0]         prop_gain;
  logic [GAIN_W-1:0]         integ_gain;
  logic [LIM_W-1:0]          accel_lim;
  logic [LIM_W-1:0]          integ_lim;
  logic [DUTY_W-1:0]         duty_total;
  logic [DUTY_W-1:0]         duty_cap;
  logic signed [INTEG_W-1:0] integ_acc;
  logic [DUTY_W-1:0]         left_level;

  coil_result_t duty_expect_q [$];
  int fail_cnt    = 0;
  int checked_cnt = 0;
  int heavy_cnt   = 0;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic coil_result_t balance_step(
    input  logic signed [ACCEL_W-1:0] accel_y,
    output logic signed [INTEG_W-1:0] integ_next,
    output logic [DUTY_W-1:0]         level_next
  );
    longint y, lim, glim, actual, err, integ, total, left_raw, right_raw;
    longint kp, ki, lvl, num, half, mass, left_cl, right_cl;
    coil_result_t r;
    y      = accel_y;
    lim    = accel_lim;
    glim   = integ_lim;
    kp     = prop_gain;
    ki     = integ_gain;
    lvl    = left_level;
    actual = clip(y, -lim, lim);
    err    = longint'(setp) - actual;
    integ  = clip(longint'(integ_acc) + err, -glim, glim);
    total  = (lvl << SH) + kp * err + ki * integ;
    // truncate toward zero
    left_raw  = (total < 0) ? -((-total) >> SH) : (total >> SH);
    right_raw = longint'(duty_total) - left_raw;
    r.heavy   = (left_raw >= MASS_SWITCH);
    if (r.heavy) begin
      num = -HEAVY_SLOPE_Q24 * y + (HEAVY_OFFS_Q24 << FRAC_BITS);
    end else begin
      num = (LIGHT_OFFS_Q24 << FRAC_BITS) - LIGHT_SLOPE_Q24 * right_raw * (64'sd1 << FRAC_BITS);
    end
    // round half away from zero
    half = 64'sd1 << (MCONST_FRAC - 1);
    mass = (num < 0) ? -(((-num) + half) >> MCONST_FRAC) : ((num + half) >> MCONST_FRAC);
    mass     = clip(mass, MASS_MIN, MASS_MAX);
    left_cl  = clip(left_raw, 0, longint'(duty_cap));
    right_cl = clip(right_raw, 0, DUTY_TOP);
    r.left_duty  = left_cl[DUTY_W-1:0];
    r.right_duty = right_cl[DUTY_W-1:0];
    r.mass_est   = mass[MASS_W-1:0];
    integ_next   = integ[INTEG_W-1:0];
    level_next   = left_cl[DUTY_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    if (fail_cnt < REPORT_MAX) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    end
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    coil_result_t want, got;
    logic signed [INTEG_W-1:0] integ_nx;
    logic [DUTY_W-1:0] level_nx;
    if (rst) begin
      setp       = SETPOINT_RESET;
      prop_gain  = PROP_RESET;
      integ_gain = INTEG_RESET;
      accel_lim  = IN_LIM_RESET;
      integ_lim  = INTEG_LIM_RESET;
      duty_total = DUTY_SUM_RESET;
      duty_cap   = DUTY_MAX_RESET;
      integ_acc  = '0;
      left_level = LEFT_RESET;
      duty_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SETPOINT:   setp       = cfg_data[SETP_W-1:0];
          REG_PROP_GAIN:  prop_gain  = cfg_data;
          REG_INTEG_GAIN: integ_gain = cfg_data;
          REG_IN_LIMIT:   accel_lim  = cfg_data[LIM_W-1:0];
          REG_INTEG_LIM:  integ_lim  = cfg_data[LIM_W-1:0];
          REG_DUTY_SUM:   duty_total = cfg_data[DUTY_W-1:0];
          REG_DUTY_MAX:   duty_cap   = cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.left_duty  = m_tdata[DUTY_W-1:0];
        got.right_duty = m_tdata[2*DUTY_W-1:DUTY_W];
        got.mass_est   = m_tdata[2*DUTY_W+MASS_W-1:2*DUTY_W];
        if (duty_expect_q.size() == 0) begin
          note_mismatch("unexpected beat, left_duty", 0, got.left_duty);
        end else begin
          want = duty_expect_q.pop_front();
          if (got.left_duty != want.left_duty)
            note_mismatch("left_duty", want.left_duty, got.left_duty);
          if (got.right_duty != want.right_duty)
            note_mismatch("right_duty", want.right_duty, got.right_duty);
          if (got.mass_est != want.mass_est)
            note_mismatch("mass_est", $signed(want.mass_est), $signed(got.mass_est));
          checked_cnt++;
        end
      end
      if (s_tvalid && s_tready) begin
        want       = balance_step(s_tdata, integ_nx, level_nx);
        integ_acc  = integ_nx;
        left_level = level_nx;
        if (want.heavy) heavy_cnt++;
        duty_expect_q.push_back(want);
      end
    end
    mismatch_count  <= fail_cnt;
    results_waiting <= duty_expect_q.size();
    results_checked <= checked_cnt;
    heavy_count     <= heavy_cnt;
  end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the coil balance loop with accel Y samples in random bursts under a
// series of register settings (reset values, all-max, all-min, random), with
// a stalling receiver; the checker predicts and compares every duty beat.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcbme_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 64;
  localparam int PHASE_ITEMS = 115;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;   // accel_y
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;          // left_duty, right_duty, mass_est
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatch_count, results_waiting, results_checked, heavy_count;

  int          burst_left  = 0;
  int          n_sent      = 0;
  int          n_settings  = 1;
  int          cur_in_lim  = IN_LIM_RESET;
  bit          drift_neg   = 1'b0;
  int          idle_cycles = 0;
  logic [15:0] rdy_pat     = '1;
  int          pat_age     = 0;

  always #2 clk = ~clk;

  pi_coil_balance_with_mass_estimate u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcbme_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_waiting (results_waiting),
    .results_checked (results_checked),
    .heavy_count     (heavy_count)
  );

  // receiver stalls on a rotating pattern, swapped now and then
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rdy_pat  <= '1;
      pat_age  <= 0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0:       rdy_pat <= '1;
          1:       rdy_pat <= 16'($urandom) | 16'h0001;
          2:       rdy_pat <= 16'($urandom & $urandom) | 16'h0001;
          default: rdy_pat <= 16'h0001 << $urandom_range(0, 15);
        endcase
        pat_age <= $urandom_range(50, 400);
      end else begin
        rdy_pat <= {rdy_pat[0], rdy_pat[15:1]};
        pat_age <= pat_age - 1;
      end
      m_tready <= rdy_pat[0];
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("no beat on any channel for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_accel(input logic [S_TDATA_W-1:0] v);
    if (burst_left == 0) begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 70))
        @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    n_sent++;
    burst_left--;
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    if (burst_left != 0) begin
      burst_left = 0;
      s_tvalid <= 1'b0;
    end
    do @(posedge clk); while (results_waiting != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry junk
  task automatic apply_settings(input int sp, input int kp, input int ki, input int il,
                                input int gl, input int ds, input int dm);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_SETPOINT,   {junk[15:13], sp[12:0]});
    write_reg(REG_PROP_GAIN,  kp[15:0]);
    write_reg(REG_INTEG_GAIN, ki[15:0]);
    write_reg(REG_IN_LIMIT,   {junk[15], il[14:0]});
    write_reg(REG_INTEG_LIM,  {junk[14], gl[14:0]});
    write_reg(REG_DUTY_SUM,   {junk[15:11], ds[10:0]});
    write_reg(REG_DUTY_MAX,   {junk[10:6], dm[10:0]});
    cur_in_lim = il;
    n_settings++;
  endtask

  function automatic int pick_value(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  // long same-sign runs wind the loop into its clamps
  function automatic logic [S_TDATA_W-1:0] next_accel();
    int mag;
    logic [S_TDATA_W-1:0] v;
    if ($urandom_range(0, 39) == 0) drift_neg = ~drift_neg;
    case ($urandom_range(0, 7))
      0: v = S_TDATA_W'($urandom);
      1: begin
        mag = cur_in_lim - 1 + int'($urandom_range(0, 2));
        v   = S_TDATA_W'(drift_neg ? -mag : mag);
      end
      default: begin
        mag = $urandom_range(0, 32767) >> $urandom_range(0, 15);
        v   = S_TDATA_W'(drift_neg ? -mag : mag);
      end
    endcase
    return v;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_accel(next_accel());
  endtask

  initial begin
    logic [S_TDATA_W-1:0] dflt_seq [$];
    logic [S_TDATA_W-1:0] max_seq [$];
    logic [S_TDATA_W-1:0] min_seq [$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    dflt_seq = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h04cd, 16'hfb33,
                 16'h04ce, 16'hfb32, 16'h0052, 16'h0053, 16'h0051, 16'h5555, 16'haaaa,
                 16'h8000, 16'h8000};
    foreach (dflt_seq[i]) send_accel(dflt_seq[i]);
    drain();

    // everything at the top: left pins high, then swings below zero
    apply_settings(4095, 65535, 65535, 32767, 32767, 2047, 2047);
    cfg_done();
    max_seq = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff};
    foreach (max_seq[i]) send_accel(max_seq[i]);
    run_random(120);
    drain();

    // zero limits and a duty cap under the kept level
    apply_settings(-4096, 0, 0, 0, 0, 0, 0);
    cfg_done();
    min_seq = '{16'h7fff, 16'h8000, 16'h0000, 16'h1234};
    foreach (min_seq[i]) send_accel(min_seq[i]);
    run_random(120);
    drain();

    apply_settings(SETPOINT_RESET, PROP_RESET, INTEG_RESET, IN_LIM_RESET, INTEG_LIM_RESET,
                   DUTY_SUM_RESET, DUTY_MAX_RESET);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_done();
    run_random(150);
    drain();

    repeat (9) begin
      apply_settings(pick_value(-4096, 4095),
                     pick_value(0, 65535) >> $urandom_range(0, 10),
                     pick_value(0, 65535) >> $urandom_range(0, 10),
                     pick_value(0, 32767) >> $urandom_range(0, 8),
                     pick_value(0, 32767) >> $urandom_range(0, 8),
                     pick_value(0, 2047),
                     pick_value(0, 2047));
      cfg_done();
      run_random(PHASE_ITEMS);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run: %0d samples over %0d register settings, %0d duty beats checked",
             n_sent, n_settings, results_checked);
    $display("heavy-branch mass estimates: %0d, mismatches: %0d, still expected: %0d",
             heavy_count, mismatch_count, results_waiting);
    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pcbme_pkg.sv
hw/rtl/pi_coil_balance_with_mass_estimate.sv
hw/rtl/pcbme_check.sv
verif/pcbme_checker.sv
verif/tb.sv
